// ===== rtl/mbd_pkg.sv =====
// Shared types, constants and table builders for the mipmap box downsampler.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package mbd_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF        = 4096;
   localparam int LINEAR_FRAC_BITS_DEF = 16;

   // Height limit and row counter width
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Alpha sum width: up to nine bytes
   localparam int ALPHA_SUM_W = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH    = 2'd0,
      CSR_SRC_HEIGHT   = 2'd1,
      CSR_PIXEL_FORMAT = 2'd2
   } mbd_csr_type;

   typedef enum logic [1:0] {
      FMT_RGBA_SRGB   = 2'd0,
      FMT_RGBA_LINEAR = 2'd1,
      FMT_RG_LINEAR   = 2'd2,
      FMT_R_LINEAR    = 2'd3
   } mbd_fmt_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ACC,
      BK_SEARCH,
      BK_DONE
   } mbd_back_state_type;

   // Per-axis window status from the axis tracker
   typedef struct packed {
      logic first;   // first source pixel of the window
      logic last;    // source pixel that closes the window
      logic at_end;  // last source pixel of the line or the level
   } mbd_axis_flags_type;

   // Control part of a queued transaction
   typedef struct packed {
      logic        first;    // opens the destination pixel: restart the sum
      logic        emit;     // closes the destination pixel
      logic        last;     // final pixel of the level
      logic        srgb;     // sRGB format: colour lanes need re-encoding
      logic [3:0]  lane_en;  // lanes used by the format
      logic [3:0]  cnt;      // source pixels in the window
      logic [10:0] col;
      logic [10:0] row;
   } mbd_ctrl_type;

   localparam int CTRL_W = $bits(mbd_ctrl_type);

   function automatic int idx_width(input int max_width);
      return ((max_width >> 1) > 1) ? $clog2(max_width >> 1) : 1;
   endfunction

   function automatic int entry_width(input int max_width, input int frac);
      return CTRL_W + idx_width(max_width) + 3 * (frac + 1) + 8;
   endfunction

   // Linear value of the sRGB code h/510 with frac fraction bits
   function automatic logic [31:0] decode_half(input int unsigned h, input int unsigned frac);
      logic [63:0] one30;
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] r2;
      logic [63:0] r4;
      logic [63:0] p5;
      logic [63:0] v;
      logic [63:0] res;
      int          k;
      one30 = 64'd1 << 30;
      if (h <= 20) begin
         res = ((64'(5 * h) << frac) + 64'd16473) / 64'd32946;
      end else begin
         a = 64'(1000 * h) + 64'd28050;
         t = ((a << 30) + 64'd269025) / 64'd538050;
         if (t > one30) t = one30;
         u  = (t * t) >> 30;
         lo = 64'd0;
         hi = one30;
         // fifth root of u by bisection
         for (k = 0; k < 32; k++) begin
            if (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               r2  = (mid * mid) >> 30;
               r4  = (r2 * r2) >> 30;
               p5  = (r4 * mid) >> 30;
               if (p5 <= u) lo = mid;
               else         hi = mid - 64'd1;
            end
         end
         v   = (u * lo) >> 30;
         res = (v + (64'd1 << (29 - frac))) >> (30 - frac);
      end
      return res[31:0];
   endfunction

endpackage

// ===== rtl/mbd_axis.sv =====
// Window tracker for one axis: source position, destination index and window bounds.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_axis #(
   parameter int W        = 13,
   parameter int MAX_SIZE = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  logic                                size_we,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]      size_wdata,
   input  logic                                advance,
   input  logic                                wrap,
   output logic [W-1:0]                        dest,
   output logic [1:0]                          span,
   output mbd_pkg::mbd_axis_flags_type         flags
);

   logic [mbd_pkg::CSR_DATA_W-1:0] size_ff, size_in;
   logic [W-1:0] pos_ff, pos_in;
   logic [W-1:0] dest_ff, dest_in;
   logic [W-1:0] start_ff, start_in;
   logic [W-1:0] end_ff, end_in;
   logic [W-1:0] rem_ff, rem_in;

   logic [W-1:0] eff_cur, eff_new, dw_cur, dw_new;
   logic [W-1:0] end_init, rem_init, rem_sum;
   logic         carry;
   logic [W:0]   pos_next;

   // Clamp a raw size into 1..MAX_SIZE
   function automatic logic [W-1:0] eff_size(input logic [mbd_pkg::CSR_DATA_W-1:0] s);
      if (s == '0) return W'(1);
      if (32'(s) > MAX_SIZE) return W'(MAX_SIZE);
      return W'(s);
   endfunction

   assign size_in = size_we ? size_wdata : size_ff;
   assign eff_cur = eff_size(size_ff);
   assign eff_new = eff_size(size_in);
   assign dw_cur  = (eff_cur > W'(1)) ? (eff_cur >> 1) : W'(1);
   assign dw_new  = (eff_new > W'(1)) ? (eff_new >> 1) : W'(1);

   // First window of a line for the new size
   always_comb begin
      if (eff_new == W'(1))                      end_init = W'(1);
      else if (dw_new == W'(1) && eff_new[0])    end_init = W'(3);
      else                                       end_init = W'(2);
      rem_init = (dw_new == W'(1)) ? '0 : W'(eff_new[0]);
   end

   // Step to the next window: two pixels, plus one when the remainder overflows
   assign rem_sum = rem_ff + W'(eff_cur[0]);
   assign carry   = rem_sum >= dw_cur;

   assign pos_next     = (W + 1)'(pos_ff) + (W + 1)'(1);
   assign flags.first  = pos_ff == start_ff;
   assign flags.last   = pos_next >= (W + 1)'(end_ff);
   assign flags.at_end = pos_next >= (W + 1)'(eff_cur);
   assign dest         = dest_ff;
   assign span         = 2'(end_ff - start_ff);

   always_comb begin
      pos_in   = pos_ff;
      dest_in  = dest_ff;
      start_in = start_ff;
      end_in   = end_ff;
      rem_in   = rem_ff;
      priority if (restart || wrap) begin
         pos_in   = '0;
         dest_in  = '0;
         start_in = '0;
         end_in   = end_init;
         rem_in   = rem_init;
      end else if (advance) begin
         pos_in = W'(pos_next);
         if (flags.last) begin
            dest_in  = dest_ff + W'(1);
            start_in = end_ff;
            end_in   = end_ff + W'(2) + W'(carry);
            rem_in   = carry ? (rem_sum - dw_cur) : rem_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= mbd_pkg::CSR_DATA_W'(1);
         pos_ff   <= '0;
         dest_ff  <= '0;
         start_ff <= '0;
         end_ff   <= W'(1);
         rem_ff   <= '0;
      end else begin
         size_ff  <= size_in;
         pos_ff   <= pos_in;
         dest_ff  <= dest_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

// ===== rtl/mbd_front.sv =====
// Front end: configuration registers, window tracking and sRGB decode of each source pixel.
// Depends on mbd_pkg and mbd_axis.
`timescale 1ns / 1ps

module mbd_front #(
   parameter int MAX_WIDTH        = mbd_pkg::MAX_WIDTH_DEF,
   parameter int LINEAR_FRAC_BITS = mbd_pkg::LINEAR_FRAC_BITS_DEF,
   parameter int ENTRY_W          = mbd_pkg::entry_width(MAX_WIDTH, LINEAR_FRAC_BITS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_ch0,
   input  logic [7:0]                         req_in_ch1,
   input  logic [7:0]                         req_in_ch2,
   input  logic [7:0]                         req_in_ch3,
   input  logic                               queue_full,
   output logic                               push,
   output logic [ENTRY_W-1:0]                 push_data
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int IW    = mbd_pkg::idx_width(MAX_WIDTH);
   localparam int LIN_W = LINEAR_FRAC_BITS + 1;

   mbd_pkg::mbd_fmt_type format_ff, format_in;
   logic restart, width_we, height_we, accept;
   logic col_adv, col_wrap, row_adv, row_wrap;
   logic [CW-1:0] col_dest;
   logic [mbd_pkg::ROW_W-1:0] row_dest;
   logic [1:0] col_span, row_span;
   mbd_pkg::mbd_axis_flags_type colf, rowf;
   mbd_pkg::mbd_ctrl_type ctrl;
   logic [LIN_W-1:0] lin_tab [256];
   logic [LIN_W-1:0] v0, v1, v2;
   logic [7:0] a;
   logic srgb;
   logic [3:0] lane_en;

   // Decode table: sRGB byte to linear fixed point
   for (genvar gi = 0; gi < 256; gi++) begin : g_lin
      localparam logic [31:0] LV = mbd_pkg::decode_half(2 * gi, LINEAR_FRAC_BITS);
      assign lin_tab[gi] = LV[LIN_W-1:0];
   end

   // Register writes; any listed register restarts the level
   assign width_we  = csr_valid && (csr_index == mbd_pkg::CSR_SRC_WIDTH);
   assign height_we = csr_valid && (csr_index == mbd_pkg::CSR_SRC_HEIGHT);
   assign restart   = width_we || height_we ||
                      (csr_valid && (csr_index == mbd_pkg::CSR_PIXEL_FORMAT));
   assign format_in = (csr_valid && (csr_index == mbd_pkg::CSR_PIXEL_FORMAT)) ?
                      mbd_pkg::mbd_fmt_type'(csr_wdata[1:0]) : format_ff;

   always_ff @(posedge clock) begin
      if (reset) format_ff <= mbd_pkg::FMT_RGBA_LINEAR;
      else       format_ff <= format_in;
   end

   // Advance the raster position on each transaction
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign col_adv   = accept && !colf.at_end;
   assign col_wrap  = accept && colf.at_end;
   assign row_adv   = accept && colf.at_end && !rowf.at_end;
   assign row_wrap  = accept && colf.at_end && rowf.at_end;

   mbd_axis #(.W(CW), .MAX_SIZE(MAX_WIDTH)) u_col (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .size_we    (width_we),
      .size_wdata (csr_wdata),
      .advance    (col_adv),
      .wrap       (col_wrap),
      .dest       (col_dest),
      .span       (col_span),
      .flags      (colf)
   );

   mbd_axis #(.W(mbd_pkg::ROW_W), .MAX_SIZE(mbd_pkg::MAX_HEIGHT)) u_row (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .size_we    (height_we),
      .size_wdata (csr_wdata),
      .advance    (row_adv),
      .wrap       (row_wrap),
      .dest       (row_dest),
      .span       (row_span),
      .flags      (rowf)
   );

   // Lanes used by the format
   always_comb begin
      unique case (format_ff)
         mbd_pkg::FMT_RGBA_SRGB:   lane_en = 4'b1111;
         mbd_pkg::FMT_RGBA_LINEAR: lane_en = 4'b1111;
         mbd_pkg::FMT_RG_LINEAR:   lane_en = 4'b0011;
         mbd_pkg::FMT_R_LINEAR:    lane_en = 4'b0001;
         default:                  lane_en = 4'b0001;
      endcase
   end

   assign srgb = format_ff == mbd_pkg::FMT_RGBA_SRGB;
   assign v0 = !lane_en[0] ? '0 : (srgb ? lin_tab[req_in_ch0] : LIN_W'(req_in_ch0));
   assign v1 = !lane_en[1] ? '0 : (srgb ? lin_tab[req_in_ch1] : LIN_W'(req_in_ch1));
   assign v2 = !lane_en[2] ? '0 : (srgb ? lin_tab[req_in_ch2] : LIN_W'(req_in_ch2));
   assign a  = lane_en[3] ? req_in_ch3 : 8'd0;

   // Classify the pixel against its windows
   always_comb begin
      ctrl.first   = colf.first && rowf.first;
      ctrl.emit    = colf.last && rowf.last;
      ctrl.last    = colf.at_end && rowf.at_end;
      ctrl.srgb    = srgb;
      ctrl.lane_en = lane_en;
      ctrl.cnt     = 4'(col_span) * 4'(row_span);
      ctrl.col     = 11'(col_dest);
      ctrl.row     = 11'(row_dest);
   end

   assign push      = accept;
   assign push_data = {ctrl, col_dest[IW-1:0], v2, v1, v0, a};

endmodule

// ===== rtl/mbd_queue.sv =====
// Short register queue between the front end and the back end.
// Depends on mbd_pkg for its default depth.
`timescale 1ns / 1ps

module mbd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == NW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop)      count_in = count_ff + NW'(1);
      else if (do_pop && !do_push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload
   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/mbd_back.sv =====
// Back end: row-store accumulation and the per-lane mean and sRGB re-encode search.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_back #(
   parameter int MAX_WIDTH        = mbd_pkg::MAX_WIDTH_DEF,
   parameter int LINEAR_FRAC_BITS = mbd_pkg::LINEAR_FRAC_BITS_DEF,
   parameter int ENTRY_W          = mbd_pkg::entry_width(MAX_WIDTH, LINEAR_FRAC_BITS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_ch0,
   output logic [7:0]         rsp_out_ch1,
   output logic [7:0]         rsp_out_ch2,
   output logic [7:0]         rsp_out_ch3,
   output logic [10:0]        rsp_out_col,
   output logic [10:0]        rsp_out_row,
   output logic               rsp_last_of_level
);

   localparam int IW     = mbd_pkg::idx_width(MAX_WIDTH);
   localparam int DEPTH  = MAX_WIDTH / 2;
   localparam int LIN_W  = LINEAR_FRAC_BITS + 1;
   localparam int SUM_W  = LIN_W + 3;
   localparam int PROD_W = LIN_W + 4;
   localparam int AW     = mbd_pkg::ALPHA_SUM_W;
   localparam int MEM_W  = 3 * SUM_W + AW;
   localparam int V_LO   = 8;
   localparam int I_LO   = 8 + 3 * LIN_W;
   localparam int C_LO   = I_LO + IW;

   mbd_pkg::mbd_back_state_type state_ff, state_in;

   logic [MEM_W-1:0] store_mem [DEPTH];
   logic [MEM_W-1:0] rd_data_ff, wr_data, base;
   logic             mem_we, acc, search_en, load_out;

   logic [ENTRY_W-1:0]    entry_ff;
   mbd_pkg::mbd_ctrl_type ctrl;
   logic [IW-1:0]         idx, pop_idx;
   logic [LIN_W-1:0]      val [3];
   logic [7:0]            a;
   logic [SUM_W-1:0]      sum [3];
   logic [AW-1:0]         asum;
   logic [SUM_W-1:0]      half_cnt;

   logic [SUM_W-1:0]  target_ff [4];
   logic [7:0]        q_ff [4];
   logic [7:0]        q_in [4];
   logic [2:0]        bit_ff;
   logic [7:0]        cand;
   logic [LIN_W-1:0]  thr_tab [256];
   logic [LIN_W-1:0]  key [4];
   logic [PROD_W-1:0] prod [4];

   logic              rsp_valid_ff;
   logic [7:0]        ch_ff [4];
   logic [10:0]       col_ff, row_ff;
   logic              last_ff;

   // Thresholds: linear value of each half code between sRGB bytes
   for (genvar gi = 0; gi < 256; gi++) begin : g_thr
      if (gi == 0) begin : g_zero
         assign thr_tab[gi] = '0;
      end else begin : g_val
         localparam logic [31:0] TV = mbd_pkg::decode_half(2 * gi - 1, LINEAR_FRAC_BITS);
         assign thr_tab[gi] = TV[LIN_W-1:0];
      end
   end

   // Unpack the queued and the held transaction
   assign pop_idx  = pop_data[I_LO +: IW];
   assign ctrl     = mbd_pkg::mbd_ctrl_type'(entry_ff[C_LO +: mbd_pkg::CTRL_W]);
   assign idx      = entry_ff[I_LO +: IW];
   assign a        = entry_ff[7:0];
   for (genvar gl = 0; gl < 3; gl++) begin : g_val_lane
      assign val[gl] = entry_ff[V_LO + gl * LIN_W +: LIN_W];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbd_pkg::BK_IDLE:   if (!queue_empty) state_in = mbd_pkg::BK_ACC;
         mbd_pkg::BK_ACC:    state_in = ctrl.emit ? mbd_pkg::BK_SEARCH : mbd_pkg::BK_IDLE;
         mbd_pkg::BK_SEARCH: if (bit_ff == 3'd0) state_in = mbd_pkg::BK_DONE;
         mbd_pkg::BK_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = mbd_pkg::BK_IDLE;
         default:            state_in = mbd_pkg::BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop       = (state_ff == mbd_pkg::BK_IDLE) && !queue_empty;
      acc       = state_ff == mbd_pkg::BK_ACC;
      mem_we    = acc;
      search_en = state_ff == mbd_pkg::BK_SEARCH;
      load_out  = (state_ff == mbd_pkg::BK_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mbd_pkg::BK_IDLE;
      else       state_ff <= state_in;
   end

   // Row store: read on pop, write back the new partial sums
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[idx] <= wr_data;
      if (pop)    rd_data_ff <= store_mem[pop_idx];
   end

   // Accumulate; the first pixel of a window starts from zero
   assign base     = ctrl.first ? '0 : rd_data_ff;
   assign half_cnt = SUM_W'(ctrl.cnt >> 1);
   for (genvar gl = 0; gl < 3; gl++) begin : g_sum
      assign sum[gl] = base[gl * SUM_W +: SUM_W] + SUM_W'(val[gl]);
   end
   assign asum    = base[3 * SUM_W +: AW] + AW'(a);
   assign wr_data = {asum, sum[2], sum[1], sum[0]};

   // Bit-by-bit search for the largest code whose scaled key stays within the target
   assign cand = 8'd1 << bit_ff;
   for (genvar gl = 0; gl < 4; gl++) begin : g_search
      if (gl < 3) begin : g_colour
         assign key[gl] = ctrl.srgb ? thr_tab[q_ff[gl] | cand] : LIN_W'(q_ff[gl] | cand);
      end else begin : g_alpha
         assign key[gl] = LIN_W'(q_ff[gl] | cand);
      end
      assign prod[gl] = PROD_W'(key[gl]) * PROD_W'(ctrl.cnt);
      assign q_in[gl] = (prod[gl] <= PROD_W'(target_ff[gl])) ? (q_ff[gl] | cand) : q_ff[gl];
   end

   always_ff @(posedge clock) begin
      if (pop) entry_ff <= pop_data;
      if (acc) begin
         bit_ff <= 3'd7;
         for (int l = 0; l < 4; l++) q_ff[l] <= 8'd0;
         for (int l = 0; l < 3; l++) target_ff[l] <= ctrl.srgb ? sum[l] : sum[l] + half_cnt;
         target_ff[3] <= SUM_W'(asum) + half_cnt;
      end else if (search_en) begin
         bit_ff <= bit_ff - 3'd1;
         for (int l = 0; l < 4; l++) q_ff[l] <= q_in[l];
      end
   end

   // Output register; unused lanes read as zero
   always_ff @(posedge clock) begin
      if (reset)                      rsp_valid_ff <= 1'b0;
      else if (load_out)              rsp_valid_ff <= 1'b1;
      else if (rsp_ready)             rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int l = 0; l < 4; l++) ch_ff[l] <= ctrl.lane_en[l] ? q_ff[l] : 8'd0;
         col_ff  <= ctrl.col;
         row_ff  <= ctrl.row;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_ch0       = ch_ff[0];
   assign rsp_out_ch1       = ch_ff[1];
   assign rsp_out_ch2       = ch_ff[2];
   assign rsp_out_ch3       = ch_ff[3];
   assign rsp_out_col       = col_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_last_of_level = last_ff;

endmodule

// ===== rtl/mipmap_box_downsampler.sv =====
// Mipmap box downsampler: builds one mipmap level from a raster stream of source pixels.
// Top level; depends on mbd_pkg, mbd_front, mbd_queue and mbd_back.
//
// Usage:
//   Program src_width, src_height and pixel_format through the csr_ channel while no
//   transaction is in flight; every write to a listed register restarts the level.
//   Source pixels enter on req_ in raster order, one transaction per pixel. Each pixel
//   that closes a destination window gives one rsp_ transaction with the averaged
//   channels, its destination column and row, and last_of_level on the final pixel.
// Back-end sequence:
//   A pixel that closes no window gets a row-store read, then accumulate and write back;
//   one that does gets the read, the accumulate, an 8-step search per lane for the mean
//   or the sRGB code, and a load of the output register, which waits while rsp is stalled.
//   The back end takes no new pixel until it is done with the last; the row-store
//   read-modify-write and the serial search set the sustained rate.
// Reset and stalls:
//   Reset restores a 1x1 rgba8 linear level; the row store needs no clearing, as the
//   first pixel of each window overwrites its entry. A stalled rsp_ready holds the output
//   register; the queue keeps taking pixels until it fills, then req_ready drops.
`timescale 1ns / 1ps

module mipmap_box_downsampler #(
   parameter int MAX_WIDTH        = mbd_pkg::MAX_WIDTH_DEF,
   parameter int LINEAR_FRAC_BITS = mbd_pkg::LINEAR_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_ch0,
   input  logic [7:0]                       req_in_ch1,
   input  logic [7:0]                       req_in_ch2,
   input  logic [7:0]                       req_in_ch3,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_ch0,
   output logic [7:0]                       rsp_out_ch1,
   output logic [7:0]                       rsp_out_ch2,
   output logic [7:0]                       rsp_out_ch3,
   output logic [10:0]                      rsp_out_col,
   output logic [10:0]                      rsp_out_row,
   output logic                             rsp_last_of_level
);

   localparam int ENTRY_W = mbd_pkg::entry_width(MAX_WIDTH, LINEAR_FRAC_BITS);

   logic               push, pop, queue_full, queue_empty;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // Registers are always writable
   assign csr_ready = 1'b1;

   mbd_front #(
      .MAX_WIDTH        (MAX_WIDTH),
      .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
      .ENTRY_W          (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_ch0 (req_in_ch0),
      .req_in_ch1 (req_in_ch1),
      .req_in_ch2 (req_in_ch2),
      .req_in_ch3 (req_in_ch3),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   mbd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (mbd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   mbd_back #(
      .MAX_WIDTH        (MAX_WIDTH),
      .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
      .ENTRY_W          (ENTRY_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_ch0       (rsp_out_ch0),
      .rsp_out_ch1       (rsp_out_ch1),
      .rsp_out_ch2       (rsp_out_ch2),
      .rsp_out_ch3       (rsp_out_ch3),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_level (rsp_last_of_level)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the mipmap box downsampler (mipmap_box_downsampler).
// A directed table, then random levels and the largest sizes, checked by a local predictor.
// Depends on rtl/mbd_pkg.sv and the RTL under rtl.
`timescale 1ns / 1ps

module tb;

   localparam logic [mbd_pkg::CSR_INDEX_W-1:0] CSR_NO_REG = 2'd3;  // index with no register
   localparam int STORE_N    = 2048;
   localparam int LIMIT_W    = 4096;
   localparam int LIMIT_H    = 4096;
   localparam int FRAC       = 16;
   localparam int SETTLE_CYC = 40;                         // settle time after the last expected result
   localparam int RAND_ITEMS = 1000;
   localparam int BIG_ITEMS  = 200;

   typedef struct packed {
      logic [7:0]  ch0;
      logic [7:0]  ch1;
      logic [7:0]  ch2;
      logic [7:0]  ch3;
      logic [10:0] col;
      logic [10:0] row;
      logic        last;
   } dst_pixel_type;

   typedef struct {
      bit                              is_csr;
      logic [mbd_pkg::CSR_INDEX_W-1:0] idx;
      logic [mbd_pkg::CSR_DATA_W-1:0]  wdata;
      logic [7:0]                      px [4];
      bit                              has_exp;
      dst_pixel_type                   exp_px;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [mbd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mbd_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_in_ch0, req_in_ch1, req_in_ch2, req_in_ch3;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [7:0]                      rsp_out_ch0, rsp_out_ch1, rsp_out_ch2, rsp_out_ch3;
   logic [10:0]                     rsp_out_col, rsp_out_row;
   logic                            rsp_last_of_level;

   mipmap_box_downsampler u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_ch0        (req_in_ch0),
      .req_in_ch1        (req_in_ch1),
      .req_in_ch2        (req_in_ch2),
      .req_in_ch3        (req_in_ch3),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_ch0       (rsp_out_ch0),
      .rsp_out_ch1       (rsp_out_ch1),
      .rsp_out_ch2       (rsp_out_ch2),
      .rsp_out_ch3       (rsp_out_ch3),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_level (rsp_last_of_level)
   );

   // Predictor state
   longint unsigned      lin_lut [256];
   longint unsigned      thr_lut [256];
   int unsigned          cfg_w, cfg_h;
   mbd_pkg::mbd_fmt_type cfg_fmt;
   int unsigned          src_c, src_r, dst_c, dst_r, c_end, r_end;
   longint unsigned      colour_sum [STORE_N][3];
   int unsigned          alpha_sum [STORE_N];

   dst_pixel_type pending_px [$];
   stim_row_type  stim_table [$];
   int            errors;
   bit            calm_rsp;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   // Linear value of the sRGB half code h/510, Q1.16
   function automatic longint unsigned half_code_to_lin(int unsigned h);
      longint unsigned one, a, t, u, lo, hi, mid, p;
      one = 64'd1 << 30;
      if (h <= 20) return ((longint'(5 * h) << FRAC) + 16473) / 32946;
      a = 1000 * h + 28050;
      t = ((a << 30) + 269025) / 538050;
      if (t > one) t = one;
      u  = q30_mul(t, t);
      lo = 0;
      hi = one;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         p   = q30_mul(q30_mul(q30_mul(mid, mid), q30_mul(mid, mid)), mid);
         if (p <= u) lo = mid;
         else        hi = mid - 1;
      end
      return (q30_mul(u, lo) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
   endfunction

   function automatic int unsigned clamp_size(int unsigned s, int unsigned lim);
      if (s == 0) return 1;
      return (s > lim) ? lim : s;
   endfunction

   function automatic int unsigned halve(int unsigned s);
      return (s > 1) ? s / 2 : 1;
   endfunction

   function automatic int unsigned span_start(int unsigned i, int unsigned s, int unsigned d);
      return 32'((longint'(i) * s) / d);
   endfunction

   function automatic int unsigned span_end(int unsigned i, int unsigned s, int unsigned d);
      longint unsigned e;
      e = (longint'(i) + 1) * s / d;
      if (e < 1) e = 1;
      if (e > s) e = s;
      return 32'(e);
   endfunction

   // Return the level to its first pixel and clear the row sums
   function automatic void restart_level();
      int unsigned w, h;
      w = clamp_size(cfg_w, LIMIT_W);
      h = clamp_size(cfg_h, LIMIT_H);
      src_c = 0; src_r = 0; dst_c = 0; dst_r = 0;
      c_end = span_end(0, w, halve(w));
      r_end = span_end(0, h, halve(h));
      for (int i = 0; i < STORE_N; i++) begin
         colour_sum[i] = '{0, 0, 0};
         alpha_sum[i]  = 0;
      end
   endfunction

   function automatic void write_reg(logic [mbd_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [mbd_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         mbd_pkg::CSR_SRC_WIDTH:    cfg_w = 32'(val);
         mbd_pkg::CSR_SRC_HEIGHT:   cfg_h = 32'(val);
         mbd_pkg::CSR_PIXEL_FORMAT: cfg_fmt = mbd_pkg::mbd_fmt_type'(val[1:0]);
         default:                   return;
      endcase
      restart_level();
   endfunction

   // Accumulate one source pixel; returns 1 with the destination pixel when a window closes
   function automatic bit box_filter_step(logic [7:0] px [4], output dst_pixel_type res);
      int unsigned     w, h, dw, dh, nch, idx, b;
      longint unsigned cnt, acc;
      logic [7:0]      val [3];
      bit              srgb, col_last, row_last, line_end, level_end, hit;
      w    = clamp_size(cfg_w, LIMIT_W);
      h    = clamp_size(cfg_h, LIMIT_H);
      dw   = halve(w);
      dh   = halve(h);
      srgb = (cfg_fmt == mbd_pkg::FMT_RGBA_SRGB);
      nch  = (cfg_fmt == mbd_pkg::FMT_RGBA_SRGB || cfg_fmt == mbd_pkg::FMT_RGBA_LINEAR) ? 4 :
             (cfg_fmt == mbd_pkg::FMT_RG_LINEAR) ? 2 : 1;
      idx  = dst_c % STORE_N;
      hit  = 0;
      res  = '0;
      for (int c = 0; c < 3; c++)
         if (c < nch) colour_sum[idx][c] += srgb ? lin_lut[px[c]] : px[c];
      if (nch == 4) alpha_sum[idx] += px[3];
      col_last  = (src_c + 1 >= c_end);
      row_last  = (src_r + 1 >= r_end);
      line_end  = (src_c + 1 >= w);
      level_end = line_end && (src_r + 1 >= h);
      if (col_last && row_last) begin
         cnt = longint'(c_end - span_start(dst_c, w, dw)) *
               longint'(r_end - span_start(dst_r, h, dh));
         if (cnt == 0) cnt = 1;
         for (int c = 0; c < 3; c++) begin
            acc = 0;
            if (c < nch) begin
               if (srgb) begin
                  for (b = 1; b < 256; b++)
                     if (colour_sum[idx][c] >= thr_lut[b] * cnt) acc++;
               end else begin
                  acc = (colour_sum[idx][c] + cnt / 2) / cnt;
               end
            end
            val[c] = acc[7:0];
            colour_sum[idx][c] = 0;
         end
         res.ch0  = val[0];
         res.ch1  = val[1];
         res.ch2  = val[2];
         acc      = (nch == 4) ? (alpha_sum[idx] + cnt / 2) / cnt : 0;
         res.ch3  = acc[7:0];
         alpha_sum[idx] = 0;
         res.col  = dst_c[10:0];
         res.row  = dst_r[10:0];
         res.last = level_end;
         hit      = 1;
      end
      // Advance the raster position and the windows
      if (line_end) begin
         src_c = 0;
         dst_c = 0;
         c_end = span_end(0, w, dw);
         if (level_end) begin
            src_r = 0;
            dst_r = 0;
            r_end = span_end(0, h, dh);
         end else begin
            if (row_last) begin
               dst_r++;
               r_end = span_end(dst_r, h, dh);
            end
            src_r++;
         end
      end else begin
         src_c++;
         if (col_last) begin
            dst_c++;
            c_end = span_end(dst_c, w, dw);
         end
      end
      return hit;
   endfunction

   function automatic int gap_len();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 93) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // Receiver back-pressure
   int stall_left;
   always @(posedge clock) begin
      if (reset || calm_rsp) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= gap_len();
      end
   end

   // Compare each result transaction against the oldest expectation
   always @(posedge clock) begin
      dst_pixel_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_ch0, rsp_out_ch1, rsp_out_ch2, rsp_out_ch3,
                 rsp_out_col, rsp_out_row, rsp_last_of_level};
         if (pending_px.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
         end else begin
            want = pending_px.pop_front();
            if (got.ch0 !== want.ch0) begin
               $display("%0t: ch0 expected %0d actual %0d", $time, want.ch0, got.ch0);
               errors++;
            end
            if (got.ch1 !== want.ch1) begin
               $display("%0t: ch1 expected %0d actual %0d", $time, want.ch1, got.ch1);
               errors++;
            end
            if (got.ch2 !== want.ch2) begin
               $display("%0t: ch2 expected %0d actual %0d", $time, want.ch2, got.ch2);
               errors++;
            end
            if (got.ch3 !== want.ch3) begin
               $display("%0t: ch3 expected %0d actual %0d", $time, want.ch3, got.ch3);
               errors++;
            end
            if (got.col !== want.col) begin
               $display("%0t: col expected %0d actual %0d", $time, want.col, got.col);
               errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_px.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Write one register once the block has drained
   task automatic csr_write(logic [mbd_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mbd_pkg::CSR_DATA_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      write_reg(idx, val);
   endtask

   // Hold one pixel transaction until accepted, then record its expectation
   task automatic send_pixel(logic [7:0] px [4], int gap, bit has_exp, dst_pixel_type exp_px);
      dst_pixel_type res;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_in_ch0 <= px[0];
      req_in_ch1 <= px[1];
      req_in_ch2 <= px[2];
      req_in_ch3 <= px[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (box_filter_step(px, res)) pending_px = {pending_px, (has_exp ? exp_px : res)};
   endtask

   task automatic send_random_pixel(bit quiet);
      logic [7:0] px [4];
      foreach (px[i]) px[i] = 8'($urandom_range(0, 255));
      send_pixel(px, quiet ? 0 : gap_len(), 1'b0, '0);
   endtask

   task automatic add_csr(logic [mbd_pkg::CSR_INDEX_W-1:0] idx,
                          logic [mbd_pkg::CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '{default: '0};
      r.is_csr = 1;
      r.idx    = idx;
      r.wdata  = val;
      stim_table = {stim_table, r};
   endtask

   task automatic add_px(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                         bit has_exp, dst_pixel_type e);
      stim_row_type r;
      r = '{default: '0};
      r.px      = '{a, b, c, d};
      r.has_exp = has_exp;
      r.exp_px  = e;
      stim_table = {stim_table, r};
   endtask

   task automatic run_level(logic [12:0] w, logic [12:0] h, mbd_pkg::mbd_fmt_type fmt, int n,
                            bit quiet);
      csr_write(mbd_pkg::CSR_SRC_WIDTH, w);
      csr_write(mbd_pkg::CSR_SRC_HEIGHT, h);
      csr_write(mbd_pkg::CSR_PIXEL_FORMAT, mbd_pkg::CSR_DATA_W'(fmt));
      calm_rsp = quiet;
      for (int i = 0; i < n; i++) send_random_pixel(quiet);
      req_valid <= 1'b0;
   endtask

   initial begin
      int                   sent, area, n, r, pause_at;
      logic [12:0]          w, h;
      mbd_pkg::mbd_fmt_type fmt;
      bit                   quiet;

      errors    = 0;
      calm_rsp  = 0;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      {req_in_ch0, req_in_ch1, req_in_ch2, req_in_ch3} = '0;
      for (int i = 0; i < 256; i++) begin
         lin_lut[i] = half_code_to_lin(2 * i);
         thr_lut[i] = (i == 0) ? 0 : half_code_to_lin(2 * i - 1);
      end
      cfg_w   = 1;
      cfg_h   = 1;
      cfg_fmt = mbd_pkg::FMT_RGBA_LINEAR;
      restart_level();

      // Directed rows: reset level, sRGB extremes, zero sizes, rg8 3x3, unknown index, r8 3x3
      add_px(8'h00, 8'h00, 8'h00, 8'h00, 1, '{0, 0, 0, 0, 0, 0, 1});
      add_px(8'hff, 8'hff, 8'hff, 8'hff, 1, '{255, 255, 255, 255, 0, 0, 1});
      add_csr(mbd_pkg::CSR_PIXEL_FORMAT, mbd_pkg::CSR_DATA_W'(mbd_pkg::FMT_RGBA_SRGB));
      add_px(8'hff, 8'hff, 8'hff, 8'h80, 1, '{255, 255, 255, 128, 0, 0, 1});
      add_px(8'h00, 8'h00, 8'h00, 8'h7f, 1, '{0, 0, 0, 127, 0, 0, 1});
      add_px(8'h01, 8'h37, 8'hbc, 8'h55, 0, '0);
      add_csr(mbd_pkg::CSR_SRC_WIDTH, 13'd0);
      add_csr(mbd_pkg::CSR_SRC_HEIGHT, 13'd0);
      add_px(8'h80, 8'h40, 8'h20, 8'h10, 0, '0);
      add_csr(mbd_pkg::CSR_PIXEL_FORMAT, mbd_pkg::CSR_DATA_W'(mbd_pkg::FMT_RG_LINEAR));
      add_csr(mbd_pkg::CSR_SRC_WIDTH, 13'd3);
      add_csr(mbd_pkg::CSR_SRC_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++)
         add_px(8'(i * 29), 8'(255 - i * 17), 8'hff, 8'hff, 0, '0);
      add_csr(CSR_NO_REG, 13'h1fff);
      add_csr(mbd_pkg::CSR_PIXEL_FORMAT, mbd_pkg::CSR_DATA_W'(mbd_pkg::FMT_R_LINEAR));
      for (int i = 0; i < 9; i++)
         add_px(8'(i * 31 + 7), 8'hff, 8'hff, 8'hff, 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            req_valid <= 1'b0;
            csr_write(stim_table[i].idx, stim_table[i].wdata);
         end else begin
            send_pixel(stim_table[i].px, gap_len(), stim_table[i].has_exp, stim_table[i].exp_px);
         end
      end
      req_valid <= 1'b0;

      // Random levels, mostly small, some partial, some wrapping to a second level
      sent     = 0;
      pause_at = 600;
      while (sent < RAND_ITEMS) begin
         r = int'($urandom_range(0, 99));
         if (r < 80) begin
            w = 13'($urandom_range(1, 9));
            h = 13'($urandom_range(1, 9));
         end else if (r < 95) begin
            w = 13'($urandom_range(10, 40));
            h = 13'($urandom_range(1, 6));
         end else begin
            w = 13'($urandom_range(0, 2));
            h = 13'($urandom_range(0, 3));
         end
         fmt   = mbd_pkg::mbd_fmt_type'(2'($urandom_range(0, 3)));
         quiet = ($urandom_range(0, 3) == 0);
         area  = int'(clamp_size(32'(w), LIMIT_W) * clamp_size(32'(h), LIMIT_H));
         n     = ($urandom_range(0, 99) < 15) ? int'($urandom_range(1, area))
                                               : area * int'($urandom_range(1, 2));
         csr_write(mbd_pkg::CSR_SRC_WIDTH, w);
         csr_write(mbd_pkg::CSR_SRC_HEIGHT, h);
         csr_write(mbd_pkg::CSR_PIXEL_FORMAT, mbd_pkg::CSR_DATA_W'(fmt));
         calm_rsp = quiet;
         for (int i = 0; i < n; i++) begin
            // Hold off once mid-level until the block has drained
            if (sent == pause_at) begin
               req_valid <= 1'b0;
               while (pending_px.size() != 0) @(posedge clock);
            end
            send_random_pixel(quiet);
            sent++;
         end
         req_valid <= 1'b0;
      end

      // Largest sizes: over-range width, zero height; full-height column; 4096 wide by 2 high
      run_level(13'h1fff, 13'd0, mbd_pkg::FMT_RGBA_SRGB, BIG_ITEMS, 0);
      run_level(13'd1, 13'd4097, mbd_pkg::FMT_R_LINEAR, BIG_ITEMS, 0);
      run_level(13'd4096, 13'd2, mbd_pkg::FMT_RGBA_LINEAR, 300, 0);

      calm_rsp = 0;
      wait_idle();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
